// File: sv/signed_int_to_pow2_radix_text_macros.svh
// Assertion macros used by the integer-to-text top level.
`ifndef SIGNED_INT_TO_POW2_RADIX_TEXT_MACROS_SVH
`define SIGNED_INT_TO_POW2_RADIX_TEXT_MACROS_SVH
`ifndef SYNTHESIS
`define S2PRT_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("s2prt: same-cycle check failed");
`define S2PRT_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("s2prt: next-cycle check failed");
`else
`define S2PRT_ASSERT_IMP(name, clk, rstn, ante, cons)
`define S2PRT_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif
`endif

// File: sv/s2prt_pkg.sv
// Shared constants, types and helper functions for the integer-to-text block.
package s2prt_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int MIN_R       = 1;
  localparam int MAX_R       = 5;
  localparam int DB_W        = 3;
  localparam int PAD_MAX     = MAX_R - 1;
  localparam int SH_W        = VALUE_WIDTH + PAD_MAX;
  localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);

  // Digit counts and alignment padding for each digit size
  localparam int ND1  = (VALUE_WIDTH + 0) / 1;
  localparam int ND2  = (VALUE_WIDTH + 1) / 2;
  localparam int ND3  = (VALUE_WIDTH + 2) / 3;
  localparam int ND4  = (VALUE_WIDTH + 3) / 4;
  localparam int ND5  = (VALUE_WIDTH + 4) / 5;
  localparam int PAD1 = 1 * ND1 - VALUE_WIDTH;
  localparam int PAD2 = 2 * ND2 - VALUE_WIDTH;
  localparam int PAD3 = 3 * ND3 - VALUE_WIDTH;
  localparam int PAD4 = 4 * ND4 - VALUE_WIDTH;
  localparam int PAD5 = 5 * ND5 - VALUE_WIDTH;

  localparam logic [DB_W-1:0] DIGIT_BITS_RST = DB_W'(1);

  localparam logic [6:0] CHAR_MINUS     = 7'd45;
  localparam logic [6:0] CHAR_ZERO      = 7'd48;
  localparam logic [6:0] CHAR_ALPHA_OFS = 7'd55;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SIGN,
    ST_SKIP,
    ST_DIGIT
  } s2prt_state_e;

  typedef struct packed {
    logic load;
    logic shift;
    logic emit_sign;
    logic emit_digit;
  } s2prt_cmd_t;

  typedef struct packed {
    logic neg;
    logic top_zero;
    logic cnt_one;
    logic out_free;
  } s2prt_status_t;

  // Clamp the register value into the legal digit size range
  function automatic logic [DB_W-1:0] eff_bits(input logic [DB_W-1:0] db);
    logic [DB_W-1:0] r;
    r = db;
    if (db < DB_W'(MIN_R)) r = DB_W'(MIN_R);
    if (db > DB_W'(MAX_R)) r = DB_W'(MAX_R);
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] num_digits(input logic [DB_W-1:0] r);
    logic [CNT_W-1:0] n;
    case (r)
      3'd1:    n = CNT_W'(ND1);
      3'd2:    n = CNT_W'(ND2);
      3'd3:    n = CNT_W'(ND3);
      3'd4:    n = CNT_W'(ND4);
      default: n = CNT_W'(ND5);
    endcase
    return n;
  endfunction

  function automatic logic [DB_W-1:0] pad_bits(input logic [DB_W-1:0] r);
    logic [DB_W-1:0] p;
    case (r)
      3'd1:    p = DB_W'(PAD1);
      3'd2:    p = DB_W'(PAD2);
      3'd3:    p = DB_W'(PAD3);
      3'd4:    p = DB_W'(PAD4);
      default: p = DB_W'(PAD5);
    endcase
    return p;
  endfunction

  // Map a digit to '0'-'9' then 'A'-'V'
  function automatic logic [6:0] glyph(input logic [MAX_R-1:0] d);
    logic [6:0] c;
    if (d < MAX_R'(10)) c = CHAR_ZERO + {2'b00, d};
    else                c = CHAR_ALPHA_OFS + {2'b00, d};
    return c;
  endfunction

endpackage

// File: sv/s2prt_req_if.sv
// Request channel: one signed integer per request.
interface s2prt_req_if;
  import s2prt_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// File: sv/s2prt_res_if.sv
// Result channel: one ASCII character per transfer with a last flag.
interface s2prt_res_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

// File: sv/s2prt_ctrl.sv
// Controller state machine sequencing sign, zero skipping and digit output.
module s2prt_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     req_valid_i,
  output logic                     req_ready_o,
  input  s2prt_pkg::s2prt_status_t status_i,
  output s2prt_pkg::s2prt_cmd_t    cmd_o
);
  import s2prt_pkg::*;

  s2prt_state_e state_q, state_d;

  // Hold the state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) state_d = ST_SIGN;
      end
      ST_SIGN: begin
        if (!status_i.neg || status_i.out_free) state_d = ST_SKIP;
      end
      ST_SKIP: begin
        if (!status_i.top_zero || status_i.cnt_one) state_d = ST_DIGIT;
      end
      ST_DIGIT: begin
        if (status_i.out_free && status_i.cnt_one) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    req_ready_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.load  = req_valid_i;
      end
      ST_SIGN: begin
        cmd_o.emit_sign = status_i.neg && status_i.out_free;
      end
      ST_SKIP: begin
        cmd_o.shift = status_i.top_zero && !status_i.cnt_one;
      end
      ST_DIGIT: begin
        cmd_o.emit_digit = status_i.out_free;
        cmd_o.shift      = status_i.out_free && !status_i.cnt_one;
      end
      default: begin
        req_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// File: sv/s2prt_dp.sv
// Datapath: magnitude shift register, digit counter and output register.
module s2prt_dp (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [s2prt_pkg::DB_W-1:0]              cfg_wdata_i,
  input  logic signed [s2prt_pkg::VALUE_WIDTH-1:0] in_value_i,
  input  s2prt_pkg::s2prt_cmd_t                   cmd_i,
  output s2prt_pkg::s2prt_status_t                status_o,
  s2prt_res_if.source                             res_o
);
  import s2prt_pkg::*;

  logic [DB_W-1:0]        digit_bits_q;
  logic [SH_W-1:0]        sh_q, sh_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   neg_q, neg_d;
  logic                   out_valid_q, out_valid_d;
  logic [6:0]             char_q, char_d;
  logic                   last_q, last_d;
  logic [DB_W-1:0]        r_eff;
  logic [VALUE_WIDTH-1:0] mag;
  logic [MAX_R-1:0]       digit;
  logic                   out_free;

  assign r_eff    = eff_bits(digit_bits_q);
  assign mag      = in_value_i[VALUE_WIDTH-1] ? (~in_value_i + VALUE_WIDTH'(1)) : in_value_i;
  assign digit    = sh_q[SH_W-1 -: MAX_R] >> (DB_W'(MAX_R) - r_eff);
  assign out_free = !out_valid_q || res_o.ready;

  assign status_o.neg      = neg_q;
  assign status_o.top_zero = (digit == '0);
  assign status_o.cnt_one  = (cnt_q == CNT_W'(1));
  assign status_o.out_free = out_free;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_bits_q <= DIGIT_BITS_RST;
    end else if (cfg_we_i) begin
      digit_bits_q <= cfg_wdata_i;
    end
  end

  // Load the aligned magnitude, or advance one digit
  always_comb begin
    sh_d  = sh_q;
    cnt_d = cnt_q;
    neg_d = neg_q;
    if (cmd_i.load) begin
      sh_d  = {mag, {PAD_MAX{1'b0}}} >> pad_bits(r_eff);
      cnt_d = num_digits(r_eff);
      neg_d = in_value_i[VALUE_WIDTH-1];
    end else if (cmd_i.shift) begin
      sh_d  = sh_q << r_eff;
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    cnt_q  <= cnt_d;
    neg_q  <= neg_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  // Output register: fill on emit, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    if (cmd_i.emit_sign) begin
      out_valid_d = 1'b1;
      char_d      = CHAR_MINUS;
      last_d      = 1'b0;
    end else if (cmd_i.emit_digit) begin
      out_valid_d = 1'b1;
      char_d      = glyph(digit);
      last_d      = status_o.cnt_one;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.char_code = char_q;
  assign res_o.last      = last_q;

endmodule

// File: sv/signed_int_to_pow2_radix_text.sv
// Sequencing: a negative request has its sign registered from ST_SIGN once the output register is free;
// the first digit is registered from ST_DIGIT, after ST_SIGN and ST_SKIP, once the output is free.
// A new request is accepted only in ST_IDLE, after the last digit of the previous one; ND(r) = ceil(32 / r)
// digits per request; the shift register walks one digit per cycle while the output register is free.
// Leading zero digits are skipped one per cycle without output.
// Reset: digit_bits returns to 1, the controller goes idle and the output empties.
`include "signed_int_to_pow2_radix_text_macros.svh"
// Top level: signed integer to base 2^r ASCII text.
module signed_int_to_pow2_radix_text (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [s2prt_pkg::DB_W-1:0]   cfg_wdata_i,
  s2prt_req_if.sink                    req_i,
  s2prt_res_if.source                  res_o
);
  import s2prt_pkg::*;

  s2prt_cmd_t    cmd;
  s2prt_status_t status;
  logic          req_ready;

  assign req_i.ready = req_ready;

  s2prt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  s2prt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_value_i  (req_i.value),
    .cmd_i       (cmd),
    .status_o    (status),
    .res_o       (res_o)
  );

  // Checks on control sequencing
  `S2PRT_ASSERT_IMP(a_load_on_req, clk_i, rst_ni, cmd.load, req_i.valid && req_i.ready)
  `S2PRT_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, req_i.valid && req_i.ready, !req_i.ready)
  `S2PRT_ASSERT_IMP(a_emit_free, clk_i, rst_ni, cmd.emit_sign || cmd.emit_digit, status.out_free)
  `S2PRT_ASSERT_NEXT(a_idle_after_last, clk_i, rst_ni, cmd.emit_digit && status.cnt_one, req_i.ready && res_o.valid && res_o.last)

endmodule

// File: bench/signed_int_to_pow2_radix_text_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the signed integer to base 2^r ASCII text converter.
module signed_int_to_pow2_radix_text_tb;
  import s2prt_pkg::*;

  localparam int W = VALUE_WIDTH;

  localparam logic [6:0] MINUS_CODE   = 7'd45;
  localparam logic [6:0] DIGIT_BASE   = 7'd48;
  localparam logic [6:0] LETTER_BASE  = 7'd55;
  localparam int         RANDOM_COUNT = 25;

  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } text_char_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [DB_W-1:0] cfg_wdata_i;

  s2prt_req_if req_if ();
  s2prt_res_if res_if ();

  signed_int_to_pow2_radix_text i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .res_o       (res_if)
  );

  // Values waiting to be sent and characters waiting to arrive
  logic signed [W-1:0] pending_values[$];
  text_char_t          expected_text[$];

  logic [DB_W-1:0] model_digit_bits;
  int unsigned     req_issued;
  int unsigned     req_accepted;
  int unsigned     chars_taken;
  int unsigned     chars_seen;
  int unsigned     send_gap;
  int unsigned     recv_stall;
  int unsigned     max_send_gap;
  int unsigned     max_recv_stall;
  int unsigned     error_count;

  // Clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Report one mismatch and count it
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Work out the text for one value at the current digit size
  function automatic void predict_text(input logic signed [W-1:0] value,
                                       input logic [DB_W-1:0] bits);
    logic [W-1:0]  magnitude;
    logic [4:0]    digit_stack[$];
    logic [4:0]    digit;
    int unsigned   r;
    text_char_t    ch;
    r = (bits == 0) ? 1 : ((bits > 5) ? 5 : int'(bits));
    magnitude = value[W-1] ? (~value + 1'b1) : value;
    do begin
      digit = 5'(magnitude) & 5'((1 << r) - 1);
      digit_stack.push_front(digit);
      magnitude = magnitude >> r;
    end while (magnitude != 0);
    if (value[W-1]) begin
      ch.code = MINUS_CODE;
      ch.last = 1'b0;
      expected_text.push_back(ch);
    end
    foreach (digit_stack[i]) begin
      ch.code = (digit_stack[i] < 10) ? DIGIT_BASE + 7'(digit_stack[i])
                                      : LETTER_BASE + 7'(digit_stack[i]);
      ch.last = (i == digit_stack.size() - 1);
      expected_text.push_back(ch);
    end
  endfunction

  // Draw a value: full range, small, truncated, extremes or powers of two
  function automatic logic signed [W-1:0] pick_value();
    logic signed [W-1:0] v;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = $urandom_range(0, 40);
      2: v = $urandom >> $urandom_range(0, W - 1);
      3: begin
        case ($urandom_range(0, 3))
          0: v = '0;
          1: v = {1'b1, {(W - 1){1'b0}}};
          2: v = {1'b0, {(W - 1){1'b1}}};
          default: v = 1;
        endcase
      end
      default: v = W'(1) << $urandom_range(0, W - 1);
    endcase
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  // Hold until nothing is in flight, then let the block settle
  task automatic wait_drained();
    while (pending_values.size() != 0 || req_accepted != req_issued ||
           expected_text.size() != 0)
      @(negedge clk_i);
    repeat (5) @(negedge clk_i);
  endtask

  task automatic write_digit_bits(input logic [DB_W-1:0] bits);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= bits;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Request driver: present the next value after a random gap
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_accepted != req_issued) begin
        // hold the request until it is taken
      end else if (send_gap > 0) begin
        req_if.valid <= 1'b0;
        send_gap--;
      end else if (pending_values.size() != 0) begin
        req_if.value <= pending_values.pop_front();
        req_if.valid <= 1'b1;
        req_issued++;
        send_gap = $urandom_range(0, max_send_gap);
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Result ready: stall a random number of cycles after each character
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (chars_seen != chars_taken) begin
        chars_seen = chars_taken;
        recv_stall = $urandom_range(0, max_recv_stall);
      end
      if (recv_stall > 0) begin
        res_if.ready <= 1'b0;
        recv_stall--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Monitor: track the register, predict on each request, check each character
  always @(posedge clk_i) begin
    text_char_t want;
    if (!rst_ni) begin
      model_digit_bits = DIGIT_BITS_RST;
    end else begin
      if (cfg_we_i) model_digit_bits = cfg_wdata_i;
      if (req_if.valid && req_if.ready) begin
        predict_text(req_if.value, model_digit_bits);
        req_accepted++;
      end
      if (res_if.valid && res_if.ready) begin
        chars_taken++;
        if (expected_text.size() == 0) begin
          report_mismatch("unexpected char_code", res_if.char_code, -1);
        end else begin
          want = expected_text.pop_front();
          if (res_if.char_code !== want.code)
            report_mismatch("char_code", res_if.char_code, want.code);
          if (res_if.last !== want.last)
            report_mismatch("last", res_if.last, want.last);
        end
      end
    end
  end

  // Stimulus
  initial begin
    logic signed [W-1:0] directed_values[$];
    logic [DB_W-1:0]     random_settings[$];
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    req_if.valid   = 1'b0;
    req_if.value   = '0;
    res_if.ready   = 1'b0;
    req_issued     = 0;
    req_accepted   = 0;
    chars_taken    = 0;
    chars_seen     = 0;
    send_gap       = 0;
    recv_stall     = 0;
    max_send_gap   = 6;
    max_recv_stall = 6;
    error_count    = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: zero, signs, extremes, alternating bits, top glyphs
    directed_values = '{0, 1, -1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh5555_5555,
                        32'shAAAA_AAAA, 31, -32, 32'sh0000_7FFF, 10};
    foreach (directed_values[i]) pending_values.push_back(directed_values[i]);
    wait_drained();
    write_digit_bits(3'd5);
    foreach (directed_values[i]) pending_values.push_back(directed_values[i]);
    wait_drained();

    // Random: every register value, zero and the saturating ones included
    random_settings = '{3'd0, 3'd2, 3'd3, 3'd4, 3'd6, 3'd7, 3'd5, 3'd1};
    foreach (random_settings[p]) begin
      write_digit_bits(random_settings[p]);
      max_send_gap   = (p % 3 == 1) ? 0 : 6;
      max_recv_stall = (p % 3 == 1) ? 0 : ((p % 3 == 2) ? 0 : 6);
      if (p % 4 == 3) max_send_gap = 0;
      for (int n = 0; n < RANDOM_COUNT; n++) begin
        // pause the sender mid-phase until all text has arrived
        if (n == RANDOM_COUNT / 2) wait_drained();
        pending_values.push_back(pick_value());
      end
      wait_drained();
    end

    repeat (40) @(negedge clk_i);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
